FILE: rtl/core/sctk_pkg.sv
// ----------------------------------------------------------------------------
// sctk_pkg
// Shared types and constants for the scan-code ring buffer key tracker.
// ----------------------------------------------------------------------------
package sctk_pkg;

	localparam int BUFFER_DEPTH_DEF = 64;
	localparam int CODE_W           = 8;
	localparam int KEY_W            = 7;
	localparam int FILL_W           = 7;

	localparam logic [KEY_W-1:0] TRACKED_RESET = 7'h1E;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	// controller to datapath commands, at most one active per cycle
	typedef struct packed {
		logic push;       // store a byte at the tail
		logic pop;        // read the head byte, move the head
		logic pop_empty;  // pop on an empty buffer, report only
		logic pop_load;   // head byte is back from memory, load the result
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} dp_status_t;

endpackage

FILE: rtl/core/scancode_ring_buffer_key_tracker.sv
// ----------------------------------------------------------------------------
// scancode_ring_buffer_key_tracker
// Scan-code ring buffer that overwrites the oldest byte when full, with the
// up/down state of one tracked key decoded on pop.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | cmd, scan_byte
//  out     | out_valid / out_stall| popped_code, popped_valid, overwrote_oldest,
//          |                      | buffer_empty, fill_count, key_pressed
//  cfg     | cfg_we               | cfg_wdata (tracked_code)
//
// A push or a pop of an empty buffer loads the result register directly; a pop
// of a held byte goes through the registered read port of the byte store first.
// One item is in flight at a time; a held-byte pop stalls the input during
// the read. The next beat is taken in the cycle the waiting result leaves
// the output register.
// Reset clears pointers, count and key state at once; the store needs no
// clearing pass. A stalled output holds the result and stalls the input.
module scancode_ring_buffer_key_tracker #(
	parameter int BUFFER_DEPTH = sctk_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [sctk_pkg::CODE_W-1:0]   scan_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [sctk_pkg::CODE_W-1:0]   popped_code,
	output logic                          popped_valid,
	output logic                          overwrote_oldest,
	output logic                          buffer_empty,
	output logic [sctk_pkg::FILL_W-1:0]   fill_count,
	output logic                          key_pressed,
	input  logic                          cfg_we,
	input  logic [sctk_pkg::KEY_W-1:0]    cfg_wdata
);
	import sctk_pkg::*;

	dp_cmd_t    dp_cmd;
	dp_status_t status;

	sctk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.dp_cmd    (dp_cmd)
	);

	sctk_dpath #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.dp_cmd           (dp_cmd),
		.status           (status),
		.scan_byte        (scan_byte),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.popped_code      (popped_code),
		.popped_valid     (popped_valid),
		.overwrote_oldest (overwrote_oldest),
		.buffer_empty     (buffer_empty),
		.fill_count       (fill_count),
		.key_pressed      (key_pressed)
	);

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({dp_cmd.push, dp_cmd.pop, dp_cmd.pop_empty, dp_cmd.pop_load}))
		else $error("more than one datapath command in a cycle");

	a_pop_load: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.pop |=> dp_cmd.pop_load)
		else $error("memory read not followed by result load");

	a_full_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.push && status.full |=> status.full && out_valid && overwrote_oldest)
		else $error("push into full buffer not reported as overwrite");

	a_pop_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && popped_valid |-> !overwrote_oldest && !in_stall == !out_stall)
		else $error("pop result flagged as overwrite");

endmodule

FILE: rtl/core/sctk_ctrl.sv
// ----------------------------------------------------------------------------
// sctk_ctrl
// Controller: input/output handshake and the pop sequencing.
// ----------------------------------------------------------------------------
module sctk_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  cmd,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  sctk_pkg::dp_status_t  status,
	output sctk_pkg::dp_cmd_t     dp_cmd
);
	import sctk_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_POP  = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;
	logic in_accept;
	logic out_load;

	// output register is free when empty or being taken this cycle
	assign in_stall  = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign in_accept = in_valid && !in_stall;

	always_comb begin
		dp_cmd.push      = in_accept && (cmd == CMD_PUSH);
		dp_cmd.pop       = in_accept && (cmd == CMD_POP) && !status.empty;
		dp_cmd.pop_empty = in_accept && (cmd == CMD_POP) && status.empty;
		dp_cmd.pop_load  = (state_q == ST_POP);
	end

	assign out_load = dp_cmd.push || dp_cmd.pop_empty || dp_cmd.pop_load;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (dp_cmd.pop) begin
					state_d = ST_POP;
				end
			end
			ST_POP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/core/sctk_dpath.sv
// ----------------------------------------------------------------------------
// sctk_dpath
// Datapath: byte store, head/tail pointers, fill count, key state, result.
// ----------------------------------------------------------------------------
module sctk_dpath #(
	parameter int BUFFER_DEPTH = sctk_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sctk_pkg::dp_cmd_t             dp_cmd,
	output sctk_pkg::dp_status_t          status,
	input  logic [sctk_pkg::CODE_W-1:0]   scan_byte,
	input  logic                          cfg_we,
	input  logic [sctk_pkg::KEY_W-1:0]    cfg_wdata,
	output logic [sctk_pkg::CODE_W-1:0]   popped_code,
	output logic                          popped_valid,
	output logic                          overwrote_oldest,
	output logic                          buffer_empty,
	output logic [sctk_pkg::FILL_W-1:0]   fill_count,
	output logic                          key_pressed
);
	import sctk_pkg::*;

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int CW = $clog2(BUFFER_DEPTH + 1);

	localparam logic [AW-1:0] PTR_LAST = AW'(BUFFER_DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(BUFFER_DEPTH);

	logic [CODE_W-1:0] mem [BUFFER_DEPTH];
	logic [CODE_W-1:0] rd_data_q;

	logic [AW-1:0]     head_q;
	logic [AW-1:0]     tail_q;
	logic [CW-1:0]     count_q;
	logic              key_pressed_q;
	logic [KEY_W-1:0]  tracked_q;

	logic [AW-1:0]     head_inc;
	logic [AW-1:0]     tail_inc;
	logic [CW-1:0]     count_push;
	logic              key_next;

	logic [CODE_W-1:0] popped_code_q;
	logic              popped_valid_q;
	logic              overwrote_q;
	logic              empty_q;
	logic [FILL_W-1:0] fill_q;
	logic              key_out_q;

	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == CNT_FULL);

	assign head_inc   = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
	assign tail_inc   = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
	assign count_push = status.full ? count_q : count_q + 1'b1;

	// a matching byte sets the key state from its release bit
	always_comb begin
		key_next = key_pressed_q;
		if (rd_data_q[KEY_W-1:0] == tracked_q) begin
			key_next = ~rd_data_q[CODE_W-1];
		end
	end

	// when full, tail equals head, so the tail write overwrites the oldest
	always_ff @(posedge clk) begin
		if (dp_cmd.push) begin
			mem[tail_q] <= scan_byte;
		end
		if (dp_cmd.pop) begin
			rd_data_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q        <= '0;
			tail_q        <= '0;
			count_q       <= '0;
			key_pressed_q <= 1'b0;
			tracked_q     <= TRACKED_RESET;
		end else begin
			if (cfg_we) begin
				tracked_q <= cfg_wdata;
			end
			if (dp_cmd.push) begin
				tail_q  <= tail_inc;
				count_q <= count_push;
				if (status.full) begin
					head_q <= head_inc;
				end
			end
			if (dp_cmd.pop) begin
				head_q  <= head_inc;
				count_q <= count_q - 1'b1;
			end
			if (dp_cmd.pop_load) begin
				key_pressed_q <= key_next;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (dp_cmd.push) begin
			popped_code_q  <= '0;
			popped_valid_q <= 1'b0;
			overwrote_q    <= status.full;
			empty_q        <= 1'b0;
			fill_q         <= FILL_W'(count_push);
			key_out_q      <= key_pressed_q;
		end else if (dp_cmd.pop_empty) begin
			popped_code_q  <= '0;
			popped_valid_q <= 1'b0;
			overwrote_q    <= 1'b0;
			empty_q        <= 1'b1;
			fill_q         <= '0;
			key_out_q      <= key_pressed_q;
		end else if (dp_cmd.pop_load) begin
			popped_code_q  <= rd_data_q;
			popped_valid_q <= 1'b1;
			overwrote_q    <= 1'b0;
			empty_q        <= status.empty;
			fill_q         <= FILL_W'(count_q);
			key_out_q      <= key_next;
		end
	end

	assign popped_code      = popped_code_q;
	assign popped_valid     = popped_valid_q;
	assign overwrote_oldest = overwrote_q;
	assign buffer_empty     = empty_q;
	assign fill_count       = fill_q;
	assign key_pressed      = key_out_q;

endmodule
